// ===== hdl/hmss_pkg.sv =====
// Shared types, codes and saturating fixed-point helpers for the spring-mass step core.
package hmss_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int QW = DW + FB;

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    // g = 9.81 rounded to nearest
    localparam logic signed [DW-1:0] GRAV = DW'(((64'd981 << FB) + 64'd50) / 64'd100);

    // configuration register indexes
    localparam logic [3:0] CFG_STIFF  = 4'd0;
    localparam logic [3:0] CFG_MASS   = 4'd1;
    localparam logic [3:0] CFG_DAMP   = 4'd2;
    localparam logic [3:0] CFG_REST   = 4'd3;
    localparam logic [3:0] CFG_KC     = 4'd4;
    localparam logic [3:0] CFG_DT     = 4'd5;
    localparam logic [3:0] CFG_METHOD = 4'd6;
    localparam logic [3:0] CFG_CONTACT = 4'd7;

    localparam logic [1:0] METH_EXPLICIT   = 2'd0;
    localparam logic [1:0] METH_SYMPLECTIC = 2'd1;
    localparam logic [1:0] METH_MIDPOINT   = 2'd2;
    localparam logic [1:0] METH_BACKWARD   = 2'd3;

    // micro-operations
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_NEG  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_CMUL = 4'd4;
    localparam logic [3:0] OP_SELC = 4'd5;
    localparam logic [3:0] OP_DIV  = 4'd6;
    localparam logic [3:0] OP_CALL = 4'd7;
    localparam logic [3:0] OP_RET  = 4'd8;
    localparam logic [3:0] OP_END  = 4'd9;

    // operand file
    localparam logic [4:0] R_Z   = 5'd0;
    localparam logic [4:0] R_P   = 5'd1;
    localparam logic [4:0] R_V   = 5'd2;
    localparam logic [4:0] R_AN  = 5'd3;
    localparam logic [4:0] R_K   = 5'd4;
    localparam logic [4:0] R_M   = 5'd5;
    localparam logic [4:0] R_D   = 5'd6;
    localparam logic [4:0] R_L   = 5'd7;
    localparam logic [4:0] R_KC  = 5'd8;
    localparam logic [4:0] R_DT  = 5'd9;
    localparam logic [4:0] R_H   = 5'd10;
    localparam logic [4:0] R_G   = 5'd11;
    localparam logic [4:0] R_LP  = 5'd12;
    localparam logic [4:0] R_LV  = 5'd13;
    localparam logic [4:0] R_T1  = 5'd16;
    localparam logic [4:0] R_T2  = 5'd17;
    localparam logic [4:0] R_T3  = 5'd18;
    localparam logic [4:0] R_T4  = 5'd19;
    localparam logic [4:0] R_X   = 5'd20;
    localparam logic [4:0] R_Y   = 5'd21;
    localparam logic [4:0] R_F   = 5'd22;
    localparam logic [4:0] R_A   = 5'd23;
    localparam logic [4:0] R_VH  = 5'd24;
    localparam logic [4:0] R_PH  = 5'd25;
    localparam logic [4:0] R_MD  = 5'd26;
    localparam logic [4:0] R_DEN = 5'd27;
    localparam logic [4:0] R_NUM = 5'd28;

    typedef struct packed {
        logic [3:0] op;
        logic [4:0] dst;
        logic [4:0] a;
        logic [4:0] b;
    } uop_t;

    typedef struct packed {
        logic issue;
        logic capture;
        logic publish;
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic       done;
        logic       out_free;
        logic [1:0] method;
    } dp_status_t;

    function automatic logic signed [DW-1:0] addq(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] negq(input logic signed [DW-1:0] a);
        return (a == VMIN) ? VMAX : -a;
    endfunction

    function automatic logic [DW-1:0] magq(input logic signed [DW-1:0] a);
        return a[DW-1] ? (~a + 1'b1) : a;
    endfunction

    // signed value from sign and magnitude, saturated
    function automatic logic signed [DW-1:0] from_mag(input logic neg, input logic [QW:0] q);
        if (!neg) begin
            if (q > QW'(VMAX)) return VMAX;
            return q[DW-1:0];
        end
        if (q > (QW'(VMAX) + 1'b1)) return VMIN;
        return DW'(~q + 1'b1);
    endfunction

endpackage

// ===== hdl/hanging_mass_spring_step_core.sv =====
// Top level of the hanging mass spring step core.
// Usage:
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one
//   register per word; it is always ready and should be used only while idle.
//   Input channel (in_valid/in_ready) takes one word: opcode 0 advances the mass
//   by one step against anchor_pos, opcode 1 loads load_pos and load_vel.
//   Output channel (out_valid/out_ready) returns one word per input word with
//   the new position and velocity.
// Sequencing: a micro-programmed sequencer drives one shared datapath, one
//   micro-operation at a time. A divide forms 48 serial quotient bits, or
//   saturates without the serial steps when the divisor is not positive.
//   Midpoint makes two force evaluations and two divides per advance word.
//   One word is in work at a time; in_ready rises together with out_valid.
// Reset: position and velocity clear to zero, registers take their reset values,
//   the output is empty.
// Stall: a finished word waits in the output register; the next input word is
//   taken meanwhile and its result holds in the core until the output frees.
module hanging_mass_spring_step_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [31:0] anchor_pos,
    input  logic signed [31:0] load_pos,
    input  logic signed [31:0] load_vel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_pos,
    output logic signed [31:0] new_vel
);
    import hmss_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    hmss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .st       (st),
        .cmd      (cmd)
    );

    hmss_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .anchor_pos (anchor_pos),
        .load_pos   (load_pos),
        .load_vel   (load_vel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .new_pos    (new_pos),
        .new_vel    (new_vel),
        .cmd        (cmd),
        .st         (st)
    );

endmodule

// ===== hdl/hmss_ctrl.sv =====
// Sequencer: micro-program store and control state machine.
module hmss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  hmss_pkg::dp_status_t st,
    output hmss_pkg::dp_cmd_t   cmd
);
    import hmss_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    localparam logic [6:0] PC_EXP  = 7'd12;
    localparam logic [6:0] PC_SYM  = 7'd21;
    localparam logic [6:0] PC_MID  = 7'd30;
    localparam logic [6:0] PC_BWD  = 7'd47;
    localparam logic [6:0] PC_LOAD = 7'd64;

    logic [1:0] state_reg, state_next;
    logic [6:0] pc_reg, pc_next, ret_reg, ret_next;
    uop_t       u;

    function automatic uop_t mk(input logic [3:0] op, input logic [4:0] d,
                                input logic [4:0] a, input logic [4:0] b);
        uop_t r;
        r.op = op; r.dst = d; r.a = a; r.b = b;
        return r;
    endfunction

    function automatic uop_t rom(input logic [6:0] pc);
        unique case (pc)
            // force F(X, Y)
            7'd0:  return mk(OP_MUL,  R_T1, R_M,  R_G);
            7'd1:  return mk(OP_NEG,  R_T1, R_T1, R_Z);
            7'd2:  return mk(OP_SUB,  R_T2, R_X,  R_AN);
            7'd3:  return mk(OP_ADD,  R_T2, R_T2, R_L);
            7'd4:  return mk(OP_MUL,  R_T2, R_K,  R_T2);
            7'd5:  return mk(OP_NEG,  R_T2, R_T2, R_Z);
            7'd6:  return mk(OP_ADD,  R_T1, R_T1, R_T2);
            7'd7:  return mk(OP_MUL,  R_T2, R_D,  R_Y);
            7'd8:  return mk(OP_SUB,  R_T1, R_T1, R_T2);
            7'd9:  return mk(OP_CMUL, R_T2, R_X,  R_KC);
            7'd10: return mk(OP_SUB,  R_F,  R_T1, R_T2);
            7'd11: return mk(OP_RET,  R_Z,  R_Z,  R_Z);
            // explicit Euler
            7'd12: return mk(OP_ADD,  R_X,  R_P,  R_Z);
            7'd13: return mk(OP_ADD,  R_Y,  R_V,  R_Z);
            7'd14: return mk(OP_CALL, R_Z,  R_Z,  R_Z);
            7'd15: return mk(OP_DIV,  R_A,  R_F,  R_M);
            7'd16: return mk(OP_MUL,  R_T3, R_DT, R_V);
            7'd17: return mk(OP_ADD,  R_P,  R_P,  R_T3);
            7'd18: return mk(OP_MUL,  R_T3, R_DT, R_A);
            7'd19: return mk(OP_ADD,  R_V,  R_V,  R_T3);
            7'd20: return mk(OP_END,  R_Z,  R_Z,  R_Z);
            // symplectic Euler
            7'd21: return mk(OP_ADD,  R_X,  R_P,  R_Z);
            7'd22: return mk(OP_ADD,  R_Y,  R_V,  R_Z);
            7'd23: return mk(OP_CALL, R_Z,  R_Z,  R_Z);
            7'd24: return mk(OP_DIV,  R_A,  R_F,  R_M);
            7'd25: return mk(OP_MUL,  R_T3, R_DT, R_A);
            7'd26: return mk(OP_ADD,  R_V,  R_V,  R_T3);
            7'd27: return mk(OP_MUL,  R_T3, R_DT, R_V);
            7'd28: return mk(OP_ADD,  R_P,  R_P,  R_T3);
            7'd29: return mk(OP_END,  R_Z,  R_Z,  R_Z);
            // midpoint
            7'd30: return mk(OP_ADD,  R_X,  R_P,  R_Z);
            7'd31: return mk(OP_ADD,  R_Y,  R_V,  R_Z);
            7'd32: return mk(OP_CALL, R_Z,  R_Z,  R_Z);
            7'd33: return mk(OP_DIV,  R_A,  R_F,  R_M);
            7'd34: return mk(OP_MUL,  R_T3, R_H,  R_A);
            7'd35: return mk(OP_ADD,  R_VH, R_V,  R_T3);
            7'd36: return mk(OP_MUL,  R_T3, R_H,  R_V);
            7'd37: return mk(OP_ADD,  R_PH, R_P,  R_T3);
            7'd38: return mk(OP_MUL,  R_T3, R_DT, R_VH);
            7'd39: return mk(OP_ADD,  R_P,  R_P,  R_T3);
            7'd40: return mk(OP_ADD,  R_X,  R_PH, R_Z);
            7'd41: return mk(OP_ADD,  R_Y,  R_VH, R_Z);
            7'd42: return mk(OP_CALL, R_Z,  R_Z,  R_Z);
            7'd43: return mk(OP_DIV,  R_A,  R_F,  R_M);
            7'd44: return mk(OP_MUL,  R_T3, R_DT, R_A);
            7'd45: return mk(OP_ADD,  R_V,  R_V,  R_T3);
            7'd46: return mk(OP_END,  R_Z,  R_Z,  R_Z);
            // backward Euler
            7'd47: return mk(OP_SELC, R_T4, R_P,  R_KC);
            7'd48: return mk(OP_MUL,  R_T3, R_DT, R_D);
            7'd49: return mk(OP_ADD,  R_MD, R_M,  R_T3);
            7'd50: return mk(OP_MUL,  R_T3, R_DT, R_DT);
            7'd51: return mk(OP_ADD,  R_T4, R_K,  R_T4);
            7'd52: return mk(OP_MUL,  R_T3, R_T3, R_T4);
            7'd53: return mk(OP_ADD,  R_DEN, R_MD, R_T3);
            7'd54: return mk(OP_ADD,  R_X,  R_P,  R_Z);
            7'd55: return mk(OP_ADD,  R_Y,  R_V,  R_Z);
            7'd56: return mk(OP_CALL, R_Z,  R_Z,  R_Z);
            7'd57: return mk(OP_MUL,  R_T3, R_MD, R_V);
            7'd58: return mk(OP_MUL,  R_T4, R_DT, R_F);
            7'd59: return mk(OP_ADD,  R_NUM, R_T3, R_T4);
            7'd60: return mk(OP_DIV,  R_V,  R_NUM, R_DEN);
            7'd61: return mk(OP_MUL,  R_T3, R_DT, R_V);
            7'd62: return mk(OP_ADD,  R_P,  R_P,  R_T3);
            7'd63: return mk(OP_END,  R_Z,  R_Z,  R_Z);
            // load
            7'd64: return mk(OP_ADD,  R_P,  R_LP, R_Z);
            7'd65: return mk(OP_ADD,  R_V,  R_LV, R_Z);
            default: return mk(OP_END, R_Z, R_Z,  R_Z);
        endcase
    endfunction

    assign u        = rom(pc_reg);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        ret_next    = ret_reg;
        cmd.issue   = 1'b0;
        cmd.capture = in_valid && in_ready;
        cmd.publish = 1'b0;
        cmd.uop     = u;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ISSUE;
                    if (opcode)
                        pc_next = PC_LOAD;
                    else
                    begin
                        unique case (st.method)
                            METH_EXPLICIT:   pc_next = PC_EXP;
                            METH_SYMPLECTIC: pc_next = PC_SYM;
                            METH_MIDPOINT:   pc_next = PC_MID;
                            default:         pc_next = PC_BWD;
                        endcase
                    end
                end
            end
            S_ISSUE:
            begin
                case (u.op)
                    OP_CALL:
                    begin
                        ret_next = pc_reg + 7'd1;
                        pc_next  = '0;
                    end
                    OP_RET:  pc_next = ret_reg;
                    OP_END:  state_next = S_OUT;
                    default:
                    begin
                        cmd.issue  = 1'b1;
                        state_next = S_WAIT;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (st.done)
                begin
                    pc_next    = pc_reg + 7'd1;
                    state_next = S_ISSUE;
                end
            end
            default:
            begin
                // hold until the output word can be replaced
                if (st.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            ret_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

// ===== hdl/hmss_dp.sv =====
// Datapath: configuration, operand file, saturating ALU, multiplier, serial divider.
module hmss_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [3:0]            cfg_index,
    input  logic [30:0]           cfg_data,
    input  logic signed [31:0]    anchor_pos,
    input  logic signed [31:0]    load_pos,
    input  logic signed [31:0]    load_vel,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    new_pos,
    output logic signed [31:0]    new_vel,
    input  hmss_pkg::dp_cmd_t     cmd,
    output hmss_pkg::dp_status_t  st
);
    import hmss_pkg::*;

    logic [30:0] k_reg, m_reg, d_reg, l_reg, kc_reg, dt_reg;
    logic [1:0]  meth_reg;
    logic        cen_reg;

    logic signed [DW-1:0] pos_reg, vel_reg, anc_reg, lp_reg, lv_reg;
    logic signed [DW-1:0] tmp_reg [16];
    logic signed [DW-1:0] npos_reg, nvel_reg;
    logic                 ov_reg;

    logic [4:0]        dst_reg;
    logic              done_reg;
    logic              mul_reg;
    logic              mneg_reg;
    logic [2*DW-1:0]   prod_reg;
    logic              div_reg;
    logic              dneg_reg;
    logic [5:0]        cnt_reg;
    logic [QW-1:0]     num_reg, q_reg;
    logic [DW-1:0]     r_reg, dv_reg;

    logic signed [DW-1:0] opa, opb, alu_res, wr_val;
    logic                 wr_en;
    logic [4:0]           wr_dst;
    logic                 is_mul, is_div, div_zero, contact_a;
    logic [DW:0]          r_try;
    logic                 r_ge;
    logic [DW-1:0]        r_new;
    logic [QW:0]          q_fin, mq;

    function automatic logic signed [DW-1:0] rd(input logic [4:0] i);
        if (i[4]) return tmp_reg[i[3:0]];
        unique case (i[3:0])
            R_P[3:0]:  return pos_reg;
            R_V[3:0]:  return vel_reg;
            R_AN[3:0]: return anc_reg;
            R_K[3:0]:  return {1'b0, k_reg};
            R_M[3:0]:  return {1'b0, m_reg};
            R_D[3:0]:  return {1'b0, d_reg};
            R_L[3:0]:  return {1'b0, l_reg};
            R_KC[3:0]: return {1'b0, kc_reg};
            R_DT[3:0]: return {1'b0, dt_reg};
            R_H[3:0]:  return {2'b0, dt_reg[30:1]};
            R_G[3:0]:  return GRAV;
            R_LP[3:0]: return lp_reg;
            R_LV[3:0]: return lv_reg;
            default:   return '0;
        endcase
    endfunction

    assign opa       = rd(cmd.uop.a);
    assign opb       = rd(cmd.uop.b);
    assign contact_a = cen_reg && opa[DW-1];
    assign is_mul    = (cmd.uop.op == OP_MUL) || (cmd.uop.op == OP_CMUL);
    assign is_div    = (cmd.uop.op == OP_DIV);
    assign div_zero  = opb[DW-1] || (opb == '0);

    always_comb
    begin
        case (cmd.uop.op)
            OP_ADD:  alu_res = addq(opa, opb);
            OP_SUB:  alu_res = addq(opa, negq(opb));
            OP_NEG:  alu_res = negq(opa);
            OP_SELC: alu_res = contact_a ? opb : '0;
            // divisor not positive
            default: alu_res = opa[DW-1] ? VMIN : ((opa == '0) ? '0 : VMAX);
        endcase
    end

    // one restoring step of the divider
    assign r_try = {r_reg, num_reg[QW-1]};
    assign r_ge  = (r_try >= {1'b0, dv_reg});
    assign r_new = r_ge ? DW'(r_try - {1'b0, dv_reg}) : r_try[DW-1:0];
    assign q_fin = {1'b0, q_reg} + (QW+1)'(dneg_reg && (r_reg != '0));
    assign mq    = {1'b0, prod_reg[2*DW-1:FB]}
                 + (QW+1)'(mneg_reg && (prod_reg[FB-1:0] != '0));

    always_comb
    begin
        wr_en  = 1'b0;
        wr_dst = dst_reg;
        wr_val = alu_res;
        if (mul_reg)
        begin
            wr_en  = 1'b1;
            wr_val = from_mag(mneg_reg, mq);
        end
        else if (div_reg && (cnt_reg == '0))
        begin
            wr_en  = 1'b1;
            wr_val = from_mag(dneg_reg, q_fin);
        end
        else if (cmd.issue && !is_mul && (!is_div || div_zero))
        begin
            wr_en  = 1'b1;
            wr_dst = cmd.uop.dst;
        end
    end

    assign st.done     = done_reg;
    assign st.out_free = !ov_reg || out_ready;
    assign st.method   = meth_reg;
    assign out_valid   = ov_reg;
    assign new_pos     = npos_reg;
    assign new_vel     = nvel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= '0;
            m_reg    <= 31'd65536;
            d_reg    <= '0;
            l_reg    <= '0;
            kc_reg   <= '0;
            dt_reg   <= '0;
            meth_reg <= METH_EXPLICIT;
            cen_reg  <= 1'b0;
            pos_reg  <= '0;
            vel_reg  <= '0;
            ov_reg   <= 1'b0;
            done_reg <= 1'b0;
            mul_reg  <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_STIFF:   k_reg    <= cfg_data;
                    CFG_MASS:    m_reg    <= cfg_data;
                    CFG_DAMP:    d_reg    <= cfg_data;
                    CFG_REST:    l_reg    <= cfg_data;
                    CFG_KC:      kc_reg   <= cfg_data;
                    CFG_DT:      dt_reg   <= cfg_data;
                    CFG_METHOD:  meth_reg <= cfg_data[1:0];
                    CFG_CONTACT: cen_reg  <= cfg_data[0];
                    default:     ;
                endcase
            end

            done_reg <= wr_en;
            mul_reg  <= cmd.issue && is_mul;
            if (cmd.issue && is_div && !div_zero)
            begin
                div_reg <= 1'b1;
                cnt_reg <= 6'(QW);
            end
            else if (div_reg)
            begin
                if (cnt_reg == '0)
                    div_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 6'd1;
            end

            if (wr_en && (wr_dst == R_P))
                pos_reg <= wr_val;
            if (wr_en && (wr_dst == R_V))
                vel_reg <= wr_val;

            if (cmd.publish)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            anc_reg <= anchor_pos;
            lp_reg  <= load_pos;
            lv_reg  <= load_vel;
        end
        if (wr_en && wr_dst[4])
            tmp_reg[wr_dst[3:0]] <= wr_val;
        if (cmd.issue)
            dst_reg <= cmd.uop.dst;
        if (cmd.issue && is_mul)
        begin
            // contact multiply yields zero out of contact
            if ((cmd.uop.op == OP_CMUL) && !contact_a)
            begin
                prod_reg <= '0;
                mneg_reg <= 1'b0;
            end
            else
            begin
                prod_reg <= (2*DW)'(magq(opa)) * (2*DW)'(magq(opb));
                mneg_reg <= opa[DW-1] ^ opb[DW-1];
            end
        end
        if (cmd.issue && is_div)
        begin
            num_reg  <= {magq(opa), {FB{1'b0}}};
            dv_reg   <= opb;
            dneg_reg <= opa[DW-1];
            r_reg    <= '0;
            q_reg    <= '0;
        end
        else if (div_reg && (cnt_reg != '0))
        begin
            r_reg   <= r_new;
            q_reg   <= {q_reg[QW-2:0], r_ge};
            num_reg <= {num_reg[QW-2:0], 1'b0};
        end
        if (cmd.publish)
        begin
            npos_reg <= pos_reg;
            nvel_reg <= vel_reg;
        end
    end

endmodule
